### sv/rsk_pkg.sv
// Package: record type, rating limit and sort key helper for the record sorter.
`timescale 1ns / 1ps
package rsk_pkg;

    localparam int TAG_W    = 16;
    localparam int LENGTH_W = 16;
    localparam int RATING_W = 14;
    localparam int KEY_W    = 16;

    localparam logic [RATING_W-1:0] RATING_MAX = 14'd10000;

    // sort key select codes
    localparam logic KEY_RATING = 1'b0;
    localparam logic KEY_LENGTH = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [LENGTH_W-1:0] length;
        logic [RATING_W-1:0] rating;
    } rec_t;

    // key of a record under the chosen sort key
    function automatic logic [KEY_W-1:0] rec_key(input rec_t r, input logic sel);
        logic [KEY_W-1:0] k;
        if (sel == KEY_LENGTH)
        begin
            k = r.length;
        end
        else
        begin
            k = {{(KEY_W-RATING_W){1'b0}}, r.rating};
        end
        return k;
    endfunction

endpackage

### sv/rsk_in_if.sv
// Interface: input channel carrying one film record word.
`timescale 1ns / 1ps
interface rsk_in_if;
    logic                     valid;
    logic                     ready;
    logic [rsk_pkg::TAG_W-1:0]    record_tag;
    logic [rsk_pkg::LENGTH_W-1:0] film_length;
    logic [rsk_pkg::RATING_W-1:0] rating_milli;
    logic                     last_record;

    modport source (output valid, record_tag, film_length, rating_milli, last_record,
                    input ready);
    modport sink   (input valid, record_tag, film_length, rating_milli, last_record,
                    output ready);
endinterface

### sv/rsk_out_if.sv
// Interface: output channel carrying one sorted record word.
`timescale 1ns / 1ps
interface rsk_out_if;
    logic                     valid;
    logic                     ready;
    logic [rsk_pkg::TAG_W-1:0]    out_tag;
    logic [rsk_pkg::LENGTH_W-1:0] out_length;
    logic [rsk_pkg::RATING_W-1:0] out_rating;
    logic                     out_last;

    modport source (output valid, out_tag, out_length, out_rating, out_last,
                    input ready);
    modport sink   (input valid, out_tag, out_length, out_rating, out_last,
                    output ready);
endinterface

### sv/rsk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rsk_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

### sv/record_sort_by_key.sv
// Top level: record batch sorter, in-memory stable bubble sort, descending by key.
// Load: one word per cycle until the word marked last; a word beyond capacity is dropped.
// Sort: n-1 passes over the record RAM, each reading the records in order and writing back
//   the larger of the carried record and the one read; a batch of one skips the sort.
// Output: each word is read from the RAM, then presented, and held while the sink stalls.
// Reset: async active low; clears state, record count and sort key; RAM is not cleared.
`timescale 1ns / 1ps
module record_sort_by_key #(
    parameter int MAX_RECORDS = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic sort_key_we,
    input  logic sort_key_data,
    rsk_in_if.sink    rec_in,
    rsk_out_if.source rec_out
);
    import rsk_pkg::*;

    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int TW = $clog2(MAX_RECORDS + 2);

    typedef enum logic [3:0] {
        S_LOAD     = 4'b0001,
        S_SORT     = 4'b0010,
        S_OUT_RD   = 4'b0100,
        S_OUT_SHOW = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   pass_reg, pass_next;
    logic [TW-1:0]   step_reg, step_next;
    logic [AW-1:0]   out_idx_reg, out_idx_next;
    logic            sort_key_reg;
    logic            key_sel_reg, key_sel_next;
    rec_t            carry_reg, carry_next;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    rec_t            wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    rec_t            rd_data;

    rec_t            in_rec;
    logic            in_acc;
    logic            has_room;
    logic [CW-1:0]   n_eff;
    logic [TW-1:0]   n_ext;
    logic            carry_lt;
    logic [AW-1:0]   last_addr;

    rsk_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // incoming word with rating clamp
    always_comb
    begin
        in_rec.tag    = rec_in.record_tag;
        in_rec.length = rec_in.film_length;
        in_rec.rating = (rec_in.rating_milli > RATING_MAX) ? RATING_MAX : rec_in.rating_milli;
    end

    assign rec_in.ready = (state_reg == S_LOAD);
    assign in_acc       = rec_in.valid && rec_in.ready;
    assign has_room     = (count_reg < CW'(MAX_RECORDS));
    assign n_eff        = has_room ? (count_reg + CW'(1)) : count_reg;
    assign n_ext        = TW'(count_reg);
    assign last_addr    = AW'(count_reg - CW'(1));
    assign carry_lt     = (rec_key(carry_reg, key_sel_reg) < rec_key(rd_data, key_sel_reg));

    // output word straight from the RAM read register
    assign rec_out.valid      = (state_reg == S_OUT_SHOW);
    assign rec_out.out_tag    = rd_data.tag;
    assign rec_out.out_length = rd_data.length;
    assign rec_out.out_rating = rd_data.rating;
    assign rec_out.out_last   = (out_idx_reg == last_addr);

    // sequencer: load, bubble passes, readout
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pass_next    = pass_reg;
        step_next    = step_reg;
        out_idx_next = out_idx_reg;
        key_sel_next = key_sel_reg;
        carry_next   = carry_reg;
        wr_en        = 1'b0;
        wr_addr      = AW'(count_reg);
        wr_data      = in_rec;
        rd_en        = 1'b0;
        rd_addr      = AW'(step_reg);

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    wr_en      = has_room;
                    count_next = n_eff;
                    if (rec_in.last_record)
                    begin
                        key_sel_next = sort_key_reg;
                        step_next    = '0;
                        pass_next    = CW'(1);
                        out_idx_next = '0;
                        state_next   = (n_eff == CW'(1)) ? S_OUT_RD : S_SORT;
                    end
                end
            end

            S_SORT:
            begin
                // one pass: read slot j at step j, write the larger of carry and slot j-1 to slot j-2
                rd_en     = (step_reg < n_ext);
                step_next = step_reg + TW'(1);
                if (step_reg == TW'(1))
                begin
                    carry_next = rd_data;
                end
                else if (step_reg >= TW'(2) && step_reg <= n_ext)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(step_reg - TW'(2));
                    if (carry_lt)
                    begin
                        wr_data = rd_data;
                    end
                    else
                    begin
                        wr_data    = carry_reg;
                        carry_next = rd_data;
                    end
                end
                else if (step_reg > n_ext)
                begin
                    // end of pass: smallest seen settles in the last slot
                    wr_en     = 1'b1;
                    wr_addr   = last_addr;
                    wr_data   = carry_reg;
                    step_next = '0;
                    pass_next = pass_reg + CW'(1);
                    if (pass_reg == count_reg - CW'(1))
                    begin
                        state_next = S_OUT_RD;
                    end
                end
            end

            S_OUT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = out_idx_reg;
                state_next = S_OUT_SHOW;
            end

            S_OUT_SHOW:
            begin
                if (rec_out.ready)
                begin
                    if (rec_out.out_last)
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + AW'(1);
                        state_next   = S_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            pass_reg     <= '0;
            step_reg     <= '0;
            out_idx_reg  <= '0;
            key_sel_reg  <= KEY_RATING;
            sort_key_reg <= KEY_RATING;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pass_reg    <= pass_next;
            step_reg    <= step_next;
            out_idx_reg <= out_idx_next;
            key_sel_reg <= key_sel_next;
            if (sort_key_we)
            begin
                sort_key_reg <= sort_key_data;
            end
        end
    end

    // carried record during a pass
    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end
endmodule

### sv/rsk_checker.sv
// Checker: port-level assertions for the record sorter, bound to the top level.
`timescale 1ns / 1ps
module rsk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_tag,
    input logic [15:0] out_length,
    input logic [13:0] out_rating,
    input logic        out_last
);
    import rsk_pkg::*;

    // never loads a word while a sorted word is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while output valid");

    // a non-final word keeps the block loading
    a_keep_loading: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_last) |=> in_ready)
        else $error("load stopped before last word");

    // the final sorted word returns the block to loading
    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> in_ready)
        else $error("not loading after last sorted word");

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_tag) && $stable(out_length)
            && $stable(out_rating) && $stable(out_last)))
        else $error("stalled output word changed");

    // ratings leave clamped
    a_rating_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_rating <= RATING_MAX))
        else $error("output rating above range");
endmodule

bind record_sort_by_key rsk_checker u_rsk_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (rec_in.valid),
    .in_ready   (rec_in.ready),
    .in_last    (rec_in.last_record),
    .out_valid  (rec_out.valid),
    .out_ready  (rec_out.ready),
    .out_tag    (rec_out.out_tag),
    .out_length (rec_out.out_length),
    .out_rating (rec_out.out_rating),
    .out_last   (rec_out.out_last)
);

### tb/sv/tb_top.sv
// Testbench top: drives film record batches into the sorter and checks every sorted word.
`timescale 1ns / 1ps
module tb_top;
    import rsk_pkg::*;

    localparam int MAX_RECS          = 64;
    localparam int LIMIT_CYCLES      = 500000;
    localparam int TAIL_CYCLES       = 20;
    localparam int SETTLE_CYCLES     = 4;
    localparam int RANDOM_ITEMS      = 280;
    localparam int MISMATCH_PRINT_MAX = 40;

    // one expected output word: the record plus its end-of-run mark
    typedef struct packed {
        rec_t rec;
        logic last;
    } sorted_word_t;

    logic clk;
    logic rst_n;
    logic sort_key_we;
    logic sort_key_data;

    rsk_in_if  rec_in ();
    rsk_out_if rec_out ();

    rec_t         loaded_q[$];   // records of the batch being loaded
    sorted_word_t sorted_q[$];   // sorted words still owed by the block
    logic         cur_key = KEY_RATING;
    bit           idling = 1'b0;
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;

    record_sort_by_key #(
        .MAX_RECORDS(MAX_RECS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sort_key_we   (sort_key_we),
        .sort_key_data (sort_key_data),
        .rec_in        (rec_in),
        .rec_out       (rec_out)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // value a record is ordered by under the given key
    function automatic logic [15:0] order_value(input rec_t r, input logic by_length);
        if (by_length == KEY_LENGTH)
        begin
            return r.length;
        end
        return {2'b00, r.rating};
    endfunction

    // gap length: none unless idling; then mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idling || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic note_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        error_count++;
        if (error_count <= MISMATCH_PRINT_MAX)
        begin
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        end
    endtask

    // load one record; on the last one, sort the batch (stable, descending)
    task automatic absorb_record(input rec_t r, input logic last);
        rec_t         batch[$];
        rec_t         hold;
        sorted_word_t w;
        int           j;
        if (r.rating > RATING_MAX)
        begin
            r.rating = RATING_MAX;
        end
        if (loaded_q.size() < MAX_RECS)
        begin
            loaded_q.push_back(r);
        end
        if (last)
        begin
            batch = loaded_q;
            loaded_q.delete();
            // insertion sort, strict compare keeps arrival order on ties
            for (int i = 1; i < batch.size(); i++)
            begin
                hold = batch[i];
                j = i;
                while (j > 0 && order_value(batch[j-1], cur_key) < order_value(hold, cur_key))
                begin
                    batch[j] = batch[j-1];
                    j--;
                end
                batch[j] = hold;
            end
            for (int k = 0; k < batch.size(); k++)
            begin
                w.rec  = batch[k];
                w.last = (k == batch.size() - 1);
                sorted_q.push_back(w);
            end
        end
    endtask

    // input monitor
    always @(posedge clk)
    begin
        if (rst_n && rec_in.valid && rec_in.ready)
        begin
            absorb_record({rec_in.record_tag, rec_in.film_length, rec_in.rating_milli},
                          rec_in.last_record);
        end
    end

    // output checker
    always @(posedge clk)
    begin : check_out
        sorted_word_t want;
        if (rst_n && rec_out.valid && rec_out.ready)
        begin
            if (sorted_q.size() == 0)
            begin
                note_mismatch("unexpected word, tag", rec_out.out_tag, 0);
            end
            else
            begin
                want = sorted_q.pop_front();
                if (rec_out.out_tag !== want.rec.tag)
                    note_mismatch("out_tag", rec_out.out_tag, want.rec.tag);
                if (rec_out.out_length !== want.rec.length)
                    note_mismatch("out_length", rec_out.out_length, want.rec.length);
                if (rec_out.out_rating !== want.rec.rating)
                    note_mismatch("out_rating", rec_out.out_rating, want.rec.rating);
                if (rec_out.out_last !== want.last)
                    note_mismatch("out_last", rec_out.out_last, want.last);
            end
        end
    end

    // output ready: random stalls
    initial
    begin : sink_ready
        int gap;
        rec_out.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                rec_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rec_out.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // send one record word; valid stays high for a following word unless a gap is picked
    task automatic send_word(input logic [TAG_W-1:0] tag, input logic [LENGTH_W-1:0] len,
                             input logic [RATING_W-1:0] rating, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rec_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rec_in.valid        <= 1'b1;
        rec_in.record_tag   <= tag;
        rec_in.film_length  <= len;
        rec_in.rating_milli <= rating;
        rec_in.last_record  <= last;
        do
            @(posedge clk);
        while (!rec_in.ready);
    endtask

    // stop sending and let every owed word come out
    task automatic wait_idle();
        rec_in.valid <= 1'b0;
        // let the monitor take the last accepted word first
        @(posedge clk);
        while (sorted_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_key(input logic k);
        wait_idle();
        sort_key_we   <= 1'b1;
        sort_key_data <= k;
        @(posedge clk);
        sort_key_we <= 1'b0;
        cur_key = k;
    endtask

    // a batch of one record
    task automatic test_single_record();
        set_key(KEY_RATING);
        send_word(16'hFFFF, 16'h0000, 14'd0, 1'b1);
        wait_idle();
    endtask

    // rating order: extremes, clamp above range, ties
    task automatic test_rating_order();
        idling = 1'b1;
        send_word(16'h0000, 16'hFFFF, 14'd10000, 1'b0);
        send_word(16'h1234, 16'd5,    14'd16383, 1'b0);
        send_word(16'hABCD, 16'd700,  14'd0,     1'b0);
        send_word(16'h5555, 16'd0,    14'd10001, 1'b0);
        send_word(16'hAAAA, 16'd90,   14'd4999,  1'b0);
        send_word(16'hFFFF, 16'd90,   14'd0,     1'b1);
        wait_idle();
    endtask

    // length order: extremes and ties
    task automatic test_length_order();
        set_key(KEY_LENGTH);
        send_word(16'h0001, 16'd0,    14'd200,   1'b0);
        send_word(16'h0002, 16'hFFFF, 14'd9999,  1'b0);
        send_word(16'h0003, 16'd100,  14'd16383, 1'b0);
        send_word(16'h0004, 16'hFFFF, 14'd1,     1'b0);
        send_word(16'h0005, 16'd100,  14'd10000, 1'b0);
        send_word(16'h0006, 16'd1,    14'd0,     1'b1);
        wait_idle();
    endtask

    // key changed in the middle of a batch: the key at the last word wins
    task automatic test_key_mid_batch();
        set_key(KEY_LENGTH);
        send_word(16'h0A0A, 16'd10,   14'd300,  1'b0);
        send_word(16'h0B0B, 16'd5000, 14'd100,  1'b0);
        set_key(KEY_RATING);
        send_word(16'h0C0C, 16'd1,    14'd9000, 1'b0);
        send_word(16'h0D0D, 16'd60000, 14'd200, 1'b1);
        wait_idle();
    endtask

    // store full: words past capacity are dropped, the last one still ends the batch
    task automatic test_store_full();
        set_key(KEY_LENGTH);
        for (int i = 0; i < MAX_RECS + 3; i++)
        begin
            send_word(TAG_W'($urandom), LENGTH_W'($urandom),
                      RATING_W'($urandom_range(0, 16383)), i == MAX_RECS + 2);
        end
        wait_idle();
    endtask

    // random batches, mostly small, with key changes and tie-heavy content
    task automatic test_random_batches();
        int  sent;
        int  n;
        int  r;
        bit  ties;
        bit  mid_switch;
        logic [LENGTH_W-1:0] len;
        logic [RATING_W-1:0] rating;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                n = $urandom_range(1, 8);
            else if (r < 90)
                n = $urandom_range(9, 24);
            else if (r < 97)
                n = $urandom_range(25, MAX_RECS);
            else
                n = $urandom_range(MAX_RECS + 1, MAX_RECS + 4);
            idling = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 2) == 0)
            begin
                set_key(1'($urandom_range(0, 1)));
            end
            ties       = ($urandom_range(0, 3) == 0);
            mid_switch = (n > 1) && ($urandom_range(0, 9) == 0);
            for (int i = 0; i < n; i++)
            begin
                if (mid_switch && i == n / 2)
                begin
                    set_key(~cur_key);
                end
                if (ties)
                begin
                    len = LENGTH_W'($urandom_range(0, 3) * 32'h5555);
                    case ($urandom_range(0, 3))
                        0:       rating = 14'd0;
                        1:       rating = 14'd10000;
                        2:       rating = 14'd16383;
                        default: rating = 14'd5000;
                    endcase
                end
                else
                begin
                    len = LENGTH_W'($urandom);
                    if ($urandom_range(0, 99) < 15)
                        rating = RATING_W'($urandom_range(10001, 16383));
                    else
                        rating = RATING_W'($urandom_range(0, 10000));
                end
                send_word(TAG_W'($urandom), len, rating, i == n - 1);
            end
            sent += n;
        end
        wait_idle();
    endtask

    // main sequence
    initial
    begin
        rst_n               <= 1'b0;
        sort_key_we         <= 1'b0;
        sort_key_data       <= 1'b0;
        rec_in.valid        <= 1'b0;
        rec_in.record_tag   <= '0;
        rec_in.film_length  <= '0;
        rec_in.rating_milli <= '0;
        rec_in.last_record  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_record();
        test_rating_order();
        test_length_order();
        test_key_mid_batch();
        test_store_full();
        test_random_batches();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

### files.f
sv/rsk_pkg.sv
sv/rsk_in_if.sv
sv/rsk_out_if.sv
sv/rsk_ram.sv
sv/record_sort_by_key.sv
sv/rsk_checker.sv
tb/sv/tb_top.sv
